>>> sv/sle_pkg.sv
// shared types, byte codes and palette decode for the smart led spi encoder
package sle_pkg;

  localparam int LED_SLOTS    = 16;
  localparam int BITS_PER_LED = 24;

  localparam logic [7:0] PAD_CODE      = 8'h00;
  localparam logic [7:0] BIT_ZERO_CODE = 8'hC0;
  localparam logic [7:0] BIT_ONE_CODE  = 8'hF8;
  localparam logic [7:0] LEVEL_RESET   = 8'h05;

  localparam logic [3:0] PAL_OFF    = 4'd0;
  localparam logic [3:0] PAL_RED    = 4'd1;
  localparam logic [3:0] PAL_GREEN  = 4'd2;
  localparam logic [3:0] PAL_BLUE   = 4'd3;
  localparam logic [3:0] PAL_YELLOW = 4'd4;
  localparam logic [3:0] PAL_PURPLE = 4'd5;
  localparam logic [3:0] PAL_INDIGO = 4'd6;
  localparam logic [3:0] PAL_WHITE  = 4'd7;

  localparam logic MODE_DIRECT  = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  typedef struct packed {
    color_t color;
    logic   first;
    logic   last;
  } job_t;

  typedef struct packed {
    logic r;
    logic g;
    logic b;
    logic keep;
  } pal_sel_t;

  function automatic pal_sel_t pal_decode(input logic [3:0] code);
    pal_sel_t s;
    s = '0;
    unique case (code)
      PAL_OFF:    s = '0;
      PAL_RED:    s.r = 1'b1;
      PAL_GREEN:  s.g = 1'b1;
      PAL_BLUE:   s.b = 1'b1;
      PAL_YELLOW: begin s.r = 1'b1; s.g = 1'b1; end
      PAL_PURPLE: begin s.r = 1'b1; s.b = 1'b1; end
      PAL_INDIGO: begin s.g = 1'b1; s.b = 1'b1; end
      PAL_WHITE:  begin s.r = 1'b1; s.g = 1'b1; s.b = 1'b1; end
      default:    s.keep = 1'b1;
    endcase
    return s;
  endfunction

endpackage

>>> sv/sle_front.sv
// front end: level register, per-led color store and color resolution
module sle_front #(
  parameter int LED_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  input  logic             accept,
  input  logic             in_mode,
  input  logic [3:0]       in_led_index,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic [3:0]       in_palette_code,
  input  logic             in_frame_first,
  input  logic             in_frame_last,
  output sle_pkg::job_t    job
);
  import sle_pkg::*;

  localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

  logic [7:0] level_r;
  color_t     store_r [LED_SLOTS];
  logic       in_range;
  color_t     prev;
  color_t     color;
  pal_sel_t   sel;

  assign in_range = {5'd0, in_led_index} < LED_LIMIT;
  assign prev     = in_range ? store_r[in_led_index] : '0;
  assign sel      = pal_decode(in_palette_code);

  always_comb begin
    color = prev;
    if (in_mode == MODE_DIRECT) begin
      color.r = in_red;
      color.g = in_green;
      color.b = in_blue;
    end else if (!sel.keep) begin
      color.r = sel.r ? level_r : 8'd0;
      color.g = sel.g ? level_r : 8'd0;
      color.b = sel.b ? level_r : 8'd0;
    end
  end

  assign job.color = color;
  assign job.first = in_frame_first;
  assign job.last  = in_frame_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_RESET;
      for (int i = 0; i < LED_SLOTS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        level_r <= cfg_data;
      end
      if (accept && in_range) begin
        store_r[in_led_index] <= color;
      end
    end
  end

endmodule

>>> sv/sle_fifo.sv
// two-entry job queue between the front end and the serializer
module sle_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sle_pkg::job_t push_data,
  input  logic          pop,
  output sle_pkg::job_t head,
  output logic          full,
  output logic          not_empty
);
  import sle_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head      = mem_r[rd_ptr_r];
  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

>>> sv/sle_back.sv
// serializer: optional padding, 24 bit-code bytes green-red-blue msb first, optional padding
module sle_back #(
  parameter int PAD_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sle_pkg::job_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_spi_byte,
  output logic          out_last
);
  import sle_pkg::*;

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_POST = 2'd2;

  localparam logic       HAS_PAD  = PAD_BYTES > 0;
  localparam logic [4:0] PAD_END  = 5'(PAD_BYTES - 1);
  localparam logic [4:0] DATA_END = 5'(BITS_PER_LED - 1);

  logic        fresh_r, fresh_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r;
  logic [7:0]  out_spi_byte_r;
  logic        out_last_r;

  logic [1:0]  cur_ph;
  logic [4:0]  cur_cnt;
  logic [23:0] grb;
  logic [4:0]  bit_sel;
  logic        emit;
  logic        done;
  logic [7:0]  byte_val;

  assign grb     = {head.color.g, head.color.r, head.color.b};
  assign cur_ph  = fresh_r ? ((head.first && HAS_PAD) ? PH_PRE : PH_DATA) : ph_r;
  assign cur_cnt = fresh_r ? 5'd0 : cnt_r;
  assign bit_sel = DATA_END - cur_cnt;
  assign emit    = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    ph_nxt   = cur_ph;
    cnt_nxt  = cur_cnt + 5'd1;
    done     = 1'b0;
    byte_val = PAD_CODE;
    unique case (cur_ph)
      PH_PRE: begin
        if (cur_cnt == PAD_END) begin
          ph_nxt  = PH_DATA;
          cnt_nxt = 5'd0;
        end
      end
      PH_DATA: begin
        byte_val = grb[bit_sel] ? BIT_ONE_CODE : BIT_ZERO_CODE;
        if (cur_cnt == DATA_END) begin
          cnt_nxt = 5'd0;
          if (head.last && HAS_PAD) begin
            ph_nxt = PH_POST;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_POST: begin
        if (cur_cnt == PAD_END) begin
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    fresh_nxt = done;
  end

  assign pop          = emit && done;
  assign out_valid    = out_valid_r;
  assign out_spi_byte = out_spi_byte_r;
  assign out_last     = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= 1'b1;
      ph_r        <= PH_DATA;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        fresh_r     <= fresh_nxt;
        ph_r        <= ph_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_spi_byte_r <= byte_val;
      out_last_r     <= done;
    end
  end

endmodule

>>> sv/smart_led_spi_bit_encoder.sv
// top level of the smart led spi bit encoder
// Each accepted LED transaction resolves a color (direct, palette scaled by the level
// register, or the color kept in the per-LED store), writes it back to the store if
// the index is below LED_COUNT and queues it; the serializer then emits one SPI byte
// per cycle while out_stall is low: PAD_BYTES zero bytes if frame_first is set, 24
// bit-code bytes (0xC0 zero, 0xF8 one) green, red, blue msb first, and PAD_BYTES zero
// bytes if frame_last is set, with last on the final byte of each item. Items stream
// back to back through a two-entry queue; the store is cleared by reset itself, so no
// clearing pass is needed. The level register may be written through the cfg port
// whenever the block is idle; cfg_ready is always high.
module smart_led_spi_bit_encoder #(
  parameter int LED_COUNT = 16,
  parameter int PAD_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [3:0] in_led_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [3:0] in_palette_code,
  input  logic       in_frame_first,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_spi_byte,
  output logic       out_last
);
  import sle_pkg::*;

  job_t job;
  job_t head;
  logic q_full;
  logic q_not_empty;
  logic accept;
  logic pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  sle_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .accept          (accept),
    .in_mode         (in_mode),
    .in_led_index    (in_led_index),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_palette_code (in_palette_code),
    .in_frame_first  (in_frame_first),
    .in_frame_last   (in_frame_last),
    .job             (job)
  );

  sle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  sle_back #(
    .PAD_BYTES(PAD_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .head_valid   (q_not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_spi_byte (out_spi_byte),
    .out_last     (out_last)
  );

endmodule
